>>> design/bqc_pkg.sv
package bqc_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int COEF_FRAC_BITS = 14;

   // Coefficients stay below 2.0, so two integer bits cover sign and magnitude.
   localparam int COEF_W = COEF_FRAC_BITS + 2;
   localparam int PROD_W = SAMPLE_WIDTH + COEF_W;
   // Five products per section need three guard bits.
   localparam int ACC_W  = PROD_W + 3;

   localparam int NUM_TAPS = 10;
   localparam int STEP_W   = $clog2(NUM_TAPS + 1);

   localparam logic [STEP_W-1:0] STEP_S1_FIRST = STEP_W'(0);
   localparam logic [STEP_W-1:0] STEP_S1_LAST  = STEP_W'(4);
   localparam logic [STEP_W-1:0] STEP_S2_FIRST = STEP_W'(5);
   localparam logic [STEP_W-1:0] STEP_S2_LAST  = STEP_W'(9);

   // Coefficients in ten-thousandths, quantized with round half up.
   localparam logic [63:0] Q_B0 = ((64'd6293  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_B1 = ((64'd12586 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_A1 = ((64'd9747  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_A2 = ((64'd5426  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_C0 = ((64'd4754  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_C1 = ((64'd9508  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_D1 = ((64'd7363  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam logic [63:0] Q_D2 = ((64'd1654  << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;

   localparam logic signed [COEF_W-1:0] C_B0 = COEF_W'(Q_B0);
   localparam logic signed [COEF_W-1:0] C_B1 = COEF_W'(Q_B1);
   localparam logic signed [COEF_W-1:0] C_A1 = COEF_W'(Q_A1);
   localparam logic signed [COEF_W-1:0] C_A2 = COEF_W'(Q_A2);
   localparam logic signed [COEF_W-1:0] C_C0 = COEF_W'(Q_C0);
   localparam logic signed [COEF_W-1:0] C_C1 = COEF_W'(Q_C1);
   localparam logic signed [COEF_W-1:0] C_D1 = COEF_W'(Q_D1);
   localparam logic signed [COEF_W-1:0] C_D2 = COEF_W'(Q_D2);

   typedef struct packed {
      logic issue;
      logic first;
   } mac_ctl_type;

   // Signed coefficient applied at each step of the schedule; the minus
   // signs of the difference equations are folded in here.
   function automatic logic signed [COEF_W-1:0] coef_at(input logic [STEP_W-1:0] step);
      logic signed [COEF_W-1:0] c;
      case (step)
         STEP_W'(0): c = C_B0;
         STEP_W'(1): c = -C_B1;
         STEP_W'(2): c = C_B0;
         STEP_W'(3): c = C_A1;
         STEP_W'(4): c = -C_A2;
         STEP_W'(5): c = C_C0;
         STEP_W'(6): c = -C_C1;
         STEP_W'(7): c = C_C0;
         STEP_W'(8): c = C_D1;
         STEP_W'(9): c = -C_D2;
         default:    c = '0;
      endcase
      return c;
   endfunction

endpackage

>>> design/bqc_mac.sv
module bqc_mac (
   input  logic                                      clock,
   input  logic                                      reset,
   input  bqc_pkg::mac_ctl_type                      ctl,
   input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0]   op_a,
   input  logic signed [bqc_pkg::COEF_W-1:0]         coef,
   output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0]   result,
   output logic                                      clip
);
   import bqc_pkg::*;

   localparam logic signed [ACC_W:0] RND_ONE = (ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W:0] SMAX_EXT =
      {{(ACC_W - SAMPLE_WIDTH + 2){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
   localparam logic signed [ACC_W:0] SMIN_EXT =
      {{(ACC_W - SAMPLE_WIDTH + 2){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic                     prod_first_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W:0]    rnd;
   logic signed [ACC_W:0]    shf;

   assign prod_ext = $signed({{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff   <= 1'b0;
         prod_first_ff <= 1'b0;
      end else begin
         prod_vld_ff   <= ctl.issue;
         prod_first_ff <= ctl.first;
      end
      if (ctl.issue) begin
         prod_ff <= op_a * coef;
      end
      if (prod_vld_ff) begin
         acc_ff <= prod_first_ff ? prod_ext : acc_ff + prod_ext;
      end
   end

   // Round half toward plus infinity, then clip to the sample range.
   always_comb begin
      rnd = $signed({acc_ff[ACC_W-1], acc_ff}) + RND_ONE;
      shf = rnd >>> COEF_FRAC_BITS;
      if (shf > SMAX_EXT) begin
         result = SMAX_EXT[SAMPLE_WIDTH-1:0];
         clip   = 1'b1;
      end else if (shf < SMIN_EXT) begin
         result = SMIN_EXT[SAMPLE_WIDTH-1:0];
         clip   = 1'b1;
      end else begin
         result = shf[SAMPLE_WIDTH-1:0];
         clip   = 1'b0;
      end
   end

endmodule

>>> design/biquad_cascade_filter.sv
// Two cascaded direct-form-I biquad sections on one shared multiply-accumulate unit.
// An item is accepted only in the idle state, and rsp_valid rises once both sections
// finish; the steps are ten products through the single multiplier, one drain and
// one rounding step per section, and the idle state in which the next item is
// accepted. Completion waits while a presented result is held by rsp_stall.
// Reset (synchronous, active high) clears all history and drops rsp_valid.
module biquad_cascade_filter (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [bqc_pkg::SAMPLE_WIDTH-1:0]   req_sample_in,
   input  logic                                      req_restart,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [bqc_pkg::SAMPLE_WIDTH-1:0]   rsp_sample_out,
   output logic                                      rsp_saturated
);
   import bqc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE1,
      ST_WAIT1,
      ST_FIN1,
      ST_ISSUE2,
      ST_WAIT2,
      ST_FIN2
   } state_type;

   state_type                       state_ff, state_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic signed [SAMPLE_WIDTH-1:0]  x_ff, x_in;
   logic signed [SAMPLE_WIDTH-1:0]  x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SAMPLE_WIDTH-1:0]  v_ff, v_in;
   logic signed [SAMPLE_WIDTH-1:0]  v1_ff, v1_in, v2_ff, v2_in;
   logic signed [SAMPLE_WIDTH-1:0]  y1_ff, y1_in, y2_ff, y2_in;
   logic                            clip_ff, clip_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                            rsp_sat_ff, rsp_sat_in;

   mac_ctl_type                     mac_ctl;
   logic signed [SAMPLE_WIDTH-1:0]  op_a;
   logic signed [COEF_W-1:0]        coef;
   logic signed [SAMPLE_WIDTH-1:0]  mac_result;
   logic                            mac_clip;
   logic                            out_free;

   bqc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .op_a   (op_a),
      .coef   (coef),
      .result (mac_result),
      .clip   (mac_clip)
   );

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_saturated  = rsp_sat_ff;
   assign out_free       = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (step_ff)
         STEP_W'(0): op_a = x_ff;
         STEP_W'(1): op_a = x1_ff;
         STEP_W'(2): op_a = x2_ff;
         STEP_W'(3): op_a = v1_ff;
         STEP_W'(4): op_a = v2_ff;
         STEP_W'(5): op_a = v_ff;
         STEP_W'(6): op_a = v1_ff;
         STEP_W'(7): op_a = v2_ff;
         STEP_W'(8): op_a = y1_ff;
         STEP_W'(9): op_a = y2_ff;
         default:    op_a = '0;
      endcase
      coef = coef_at(step_ff);
      mac_ctl.issue = (state_ff == ST_ISSUE1) || (state_ff == ST_ISSUE2);
      mac_ctl.first = (step_ff == STEP_S1_FIRST) || (step_ff == STEP_S2_FIRST);
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      x_in          = x_ff;
      x1_in         = x1_ff;
      x2_in         = x2_ff;
      v_in          = v_ff;
      v1_in         = v1_ff;
      v2_in         = v2_ff;
      y1_in         = y1_ff;
      y2_in         = y2_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      case (state_ff)
         ST_IDLE: begin
            step_in = STEP_S1_FIRST;
            if (req_valid) begin
               x_in     = req_sample_in;
               state_in = ST_ISSUE1;
               if (req_restart) begin
                  x1_in = '0;
                  x2_in = '0;
                  v1_in = '0;
                  v2_in = '0;
                  y1_in = '0;
                  y2_in = '0;
               end
            end
         end
         ST_ISSUE1: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_S1_LAST) begin
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1: begin
            state_in = ST_FIN1;
         end
         ST_FIN1: begin
            v_in     = mac_result;
            clip_in  = mac_clip;
            state_in = ST_ISSUE2;
         end
         ST_ISSUE2: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_S2_LAST) begin
               state_in = ST_WAIT2;
            end
         end
         ST_WAIT2: begin
            state_in = ST_FIN2;
         end
         ST_FIN2: begin
            // The accumulator holds its value until the output register frees up.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = mac_result;
               rsp_sat_in    = clip_ff || mac_clip;
               x2_in         = x1_ff;
               x1_in         = x_ff;
               v2_in         = v1_ff;
               v1_in         = v_ff;
               y2_in         = y1_ff;
               y1_in         = mac_result;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         v1_ff        <= '0;
         v2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         x1_ff        <= x1_in;
         x2_ff        <= x2_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         y1_ff        <= y1_in;
         y2_ff        <= y2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff          <= x_in;
      v_ff          <= v_in;
      clip_ff       <= clip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

`ifndef NO_ASSERTIONS
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ISSUE1 && step_ff == STEP_S1_FIRST))
      else $error("accepted item did not start the first section");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_restart)
      |=> (x1_ff == '0 && x2_ff == '0 && v1_ff == '0 && y1_ff == '0))
      else $error("restart did not clear the history");

   a_issue2_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE2) |-> (step_ff >= STEP_S2_FIRST && step_ff <= STEP_S2_LAST))
      else $error("second section issued outside its tap range");

   a_fin2_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN2 && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item was not presented");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_sample_ff == $past(rsp_sample_ff)))
      else $error("waiting result was overwritten");
`endif

endmodule
